>>> hw/rtl/maa_pkg.sv
// Shared types and constants for the moving average accumulate unit.
package maa_pkg;

  localparam int unsigned MaxWindowDef = 256;
  localparam int unsigned SampleW      = 16;
  localparam int unsigned AccW         = 24;
  localparam int unsigned GainW        = 16;
  localparam int unsigned WlenW        = 9;
  localparam int unsigned CfgDataW     = 16;
  localparam int unsigned FracBits     = 14;

  // Register indexes of the configuration port
  typedef enum logic {
    RegWindowLength = 1'b0,
    RegGain         = 1'b1
  } reg_idx_e;

  // Live configuration seen by the datapath
  typedef struct packed {
    logic        [WlenW-1:0] window_length;
    logic signed [GainW-1:0] gain;
  } cfg_t;

  localparam logic        [WlenW-1:0] WlenReset = WlenW'(1);
  localparam logic signed [GainW-1:0] GainReset = GainW'(16384);

endpackage

>>> hw/rtl/maa_front.sv
// Front end: accepts items, updates the sample ring and running sum, queues the work.
module maa_front import maa_pkg::*; #(
  parameter int unsigned MAX_WINDOW = MaxWindowDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cfg_t                      cfg_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [SampleW-1:0] sample_i,
  input  logic signed [AccW-1:0]    accumulate_in_i,
  input  logic                      last_i,
  output logic                      push_o,
  output logic [SampleW + $clog2(MAX_WINDOW) + 1 + $clog2(MAX_WINDOW + 1) + AccW:0] entry_o,
  input  logic                      q_full_i
);

  localparam int unsigned AddrW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned CntW  = $clog2(MAX_WINDOW + 1);
  localparam int unsigned ExtW  = CntW + 1;
  localparam int unsigned SumW  = SampleW + $clog2(MAX_WINDOW) + 1;

  typedef enum logic [1:0] {
    F_IDLE = 2'b01,
    F_PUSH = 2'b10
  } fstate_e;

  fstate_e state_q, state_d;

  logic signed [SampleW-1:0] ring_mem [MAX_WINDOW];
  logic signed [SampleW-1:0] old_q;
  logic signed [SampleW-1:0] sample_q;
  logic signed [AccW-1:0]    acc_q;
  logic                      last_q;
  logic                      full_q;
  logic [CntW-1:0]           len_q;

  logic [AddrW-1:0]       wp_q, wp_d;
  logic signed [SumW-1:0] sum_q, sum_d;
  logic [CntW-1:0]        fill_q, fill_d;

  logic [CntW-1:0]        len;
  logic [ExtW-1:0]        wp_ext;
  logic [AddrW-1:0]       old_addr;
  logic                   accept;
  logic signed [SumW-1:0] new_sum;
  logic [CntW-1:0]        divisor;
  logic                   push;

  // Clamp the window length to 1..MAX_WINDOW
  always_comb begin
    if (cfg_i.window_length == '0) begin
      len = CntW'(1);
    end else if (32'(cfg_i.window_length) > 32'(MAX_WINDOW)) begin
      len = CntW'(MAX_WINDOW);
    end else begin
      len = CntW'(cfg_i.window_length);
    end
  end

  // Address of the sample that leaves the window
  always_comb begin
    wp_ext = ExtW'(wp_q);
    if (wp_ext >= ExtW'(len)) begin
      old_addr = AddrW'(wp_ext - ExtW'(len));
    end else begin
      old_addr = AddrW'(wp_ext + ExtW'(MAX_WINDOW) - ExtW'(len));
    end
  end

  assign in_stall_o = (state_q != F_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  // Ring write and read of the oldest sample; the read sees the entry before this write
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ring_mem[wp_q] <= sample_i;
      old_q          <= ring_mem[old_addr];
    end
  end

  // Hold the accepted item for the sum update
  always_ff @(posedge clk_i) begin
    if (accept) begin
      sample_q <= sample_i;
      acc_q    <= accumulate_in_i;
      last_q   <= last_i;
      full_q   <= (fill_q >= len);
      len_q    <= len;
    end
  end

  // Update the running sum and pick the divisor
  always_comb begin
    if (full_q) begin
      new_sum = sum_q - SumW'(old_q) + SumW'(sample_q);
      divisor = len_q;
    end else begin
      new_sum = sum_q + SumW'(sample_q);
      divisor = fill_q + CntW'(1);
    end
  end

  assign push    = (state_q == F_PUSH) && !q_full_i;
  assign push_o  = push;
  assign entry_o = {new_sum, divisor, acc_q, last_q};

  // Advance the sequencer, pointer, sum and count; a full window keeps its count
  always_comb begin
    state_d = state_q;
    wp_d    = wp_q;
    sum_d   = sum_q;
    fill_d  = fill_q;
    case (state_q)
      F_IDLE: begin
        if (accept) begin
          state_d = F_PUSH;
          wp_d    = (wp_q == AddrW'(MAX_WINDOW - 1)) ? '0 : wp_q + AddrW'(1);
        end
      end
      F_PUSH: begin
        if (push) begin
          state_d = F_IDLE;
          if (last_q) begin
            sum_d  = '0;
            fill_d = '0;
          end else begin
            sum_d  = new_sum;
            fill_d = full_q ? fill_q : divisor;
          end
        end
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      wp_q    <= '0;
      sum_q   <= '0;
      fill_q  <= '0;
    end else begin
      state_q <= state_d;
      wp_q    <= wp_d;
      sum_q   <= sum_d;
      fill_q  <= fill_d;
    end
  end

endmodule

>>> hw/rtl/maa_queue.sv
// Two-entry queue between the front end and the back end.
module maa_queue import maa_pkg::*; #(
  parameter int unsigned WIDTH = SampleW
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] slot_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = slot_q[rd_ptr_q];

  // Store the pushed item
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 2'd1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

>>> hw/rtl/maa_back.sv
// Back end: serial divide, gain multiply, saturating add and output register.
module maa_back import maa_pkg::*; #(
  parameter int unsigned MAX_WINDOW = MaxWindowDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cfg_t                   cfg_i,
  input  logic [SampleW + $clog2(MAX_WINDOW) + 1 + $clog2(MAX_WINDOW + 1) + AccW:0] entry_i,
  input  logic                   q_empty_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic signed [AccW-1:0] result_o,
  output logic                   result_last_o
);

  localparam int unsigned CntW  = $clog2(MAX_WINDOW + 1);
  localparam int unsigned SumW  = SampleW + $clog2(MAX_WINDOW) + 1;
  localparam int unsigned ProdW = SumW + GainW;
  localparam int unsigned ResW  = ProdW + 1;
  localparam int unsigned StepW = $clog2(SumW);

  localparam logic signed [AccW-1:0] AccMax = {1'b0, {(AccW - 1){1'b1}}};
  localparam logic signed [AccW-1:0] AccMin = {1'b1, {(AccW - 1){1'b0}}};

  typedef enum logic [4:0] {
    B_IDLE = 5'b00001,
    B_DIV  = 5'b00010,
    B_SIGN = 5'b00100,
    B_MUL  = 5'b01000,
    B_FIN  = 5'b10000
  } bstate_e;

  bstate_e state_q, state_d;

  logic signed [SumW-1:0] e_sum;
  logic [CntW-1:0]        e_div;
  logic signed [AccW-1:0] e_acc;
  logic                   e_last;

  logic                   neg_q;
  logic [SumW-1:0]        quo_q;
  logic [CntW-1:0]        rem_q;
  logic [CntW-1:0]        div_q;
  logic [StepW-1:0]       step_q;
  logic signed [AccW-1:0] acc_q;
  logic                   last_q;
  logic signed [SumW-1:0] avg_q;
  logic signed [ProdW-1:0] prod_q;

  logic                   out_valid_q;
  logic signed [AccW-1:0] result_q;
  logic                   result_last_q;

  logic [CntW:0]           rem_sh;
  logic                    q_bit;
  logic signed [ProdW-1:0] bias;
  logic signed [ProdW-1:0] scaled;
  logic signed [ResW-1:0]  res_w;
  logic signed [AccW-1:0]  res_sat;
  logic                    load_out;

  assign {e_sum, e_div, e_acc, e_last} = entry_i;

  assign pop_o    = (state_q == B_IDLE) && !q_empty_i;
  assign load_out = (state_q == B_FIN) && (!out_valid_q || !out_stall_i);

  // One restoring divide step per cycle
  always_comb begin
    rem_sh = {rem_q, quo_q[SumW-1]};
    q_bit  = (rem_sh >= {1'b0, div_q});
  end

  // Truncate the scaled value toward zero and saturate the sum
  always_comb begin
    bias   = prod_q[ProdW-1] ? ProdW'((1 << FracBits) - 1) : '0;
    scaled = (prod_q + bias) >>> FracBits;
    res_w  = ResW'(acc_q) + ResW'(scaled);
    if (res_w > ResW'(AccMax)) begin
      res_sat = AccMax;
    end else if (res_w < ResW'(AccMin)) begin
      res_sat = AccMin;
    end else begin
      res_sat = AccW'(res_w);
    end
  end

  // Sequence the divide, sign, multiply and finish steps
  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: begin
        if (!q_empty_i) begin
          state_d = B_DIV;
        end
      end
      B_DIV: begin
        if (step_q == StepW'(SumW - 1)) begin
          state_d = B_SIGN;
        end
      end
      B_SIGN: begin
        state_d = B_MUL;
      end
      B_MUL: begin
        state_d = B_FIN;
      end
      B_FIN: begin
        if (load_out) begin
          state_d = B_IDLE;
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: begin
        neg_q  <= e_sum[SumW-1];
        quo_q  <= e_sum[SumW-1] ? SumW'(-e_sum) : SumW'(e_sum);
        rem_q  <= '0;
        div_q  <= e_div;
        step_q <= '0;
        acc_q  <= e_acc;
        last_q <= e_last;
      end
      B_DIV: begin
        rem_q  <= q_bit ? CntW'(rem_sh - {1'b0, div_q}) : CntW'(rem_sh);
        quo_q  <= {quo_q[SumW-2:0], q_bit};
        step_q <= step_q + StepW'(1);
      end
      B_SIGN: begin
        avg_q <= neg_q ? -$signed(quo_q) : $signed(quo_q);
      end
      B_MUL: begin
        prod_q <= ProdW'(cfg_i.gain) * ProdW'(avg_q);
      end
      default: begin
      end
    endcase
  end

  // Output register holds the result until it is taken
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      result_q      <= res_sat;
      result_last_q <= last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_o      = result_q;
  assign result_last_o = result_last_q;

endmodule

>>> hw/rtl/moving_average_accumulate_unit.sv
// Top level of the moving average accumulate unit: registers, front end, queue, back end.
//
//   channel  | direction | handshake                    | payload
//   ---------+-----------+------------------------------+-------------------------------------
//   in       | input     | in_valid_i / in_stall_o      | sample_i, accumulate_in_i, last_i
//   out      | output    | out_valid_o / out_stall_i    | result_o, result_last_o
//   cfg      | input     | cfg_valid_i / cfg_ready_o    | cfg_index_i, cfg_data_i
//
// The front end takes a new item only once the previous one is queued; the back end
// handles one item at a time, with a one-bit-per-cycle restoring divider.
// Items pass front end, queue, divide, sign, multiply and finish steps and output register.
// Reset clears sum, count, ring pointer, queue and output valid; the ring needs no clearing.
// A stalled output holds its result; the back end then waits in B_FIN while the queue fills.
module moving_average_accumulate_unit import maa_pkg::*; #(
  parameter int unsigned MAX_WINDOW = MaxWindowDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [SampleW-1:0]  sample_i,
  input  logic signed [AccW-1:0]     accumulate_in_i,
  input  logic                       last_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [AccW-1:0]     result_o,
  output logic                       result_last_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [0:0]                 cfg_index_i,
  input  logic [CfgDataW-1:0]        cfg_data_i
);

  localparam int unsigned EntryW =
      SampleW + $clog2(MAX_WINDOW) + 1 + $clog2(MAX_WINDOW + 1) + AccW + 1;

  cfg_t              cfg_q;
  logic              push;
  logic              q_full;
  logic              q_empty;
  logic              pop;
  logic [EntryW-1:0] push_entry;
  logic [EntryW-1:0] pop_entry;

  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_length <= WlenReset;
      cfg_q.gain          <= GainReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (reg_idx_e'(cfg_index_i))
        RegWindowLength: cfg_q.window_length <= cfg_data_i[WlenW-1:0];
        RegGain:         cfg_q.gain          <= $signed(cfg_data_i[GainW-1:0]);
        default: begin
        end
      endcase
    end
  end

  maa_front #(
    .MAX_WINDOW(MAX_WINDOW)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .sample_i       (sample_i),
    .accumulate_in_i(accumulate_in_i),
    .last_i         (last_i),
    .push_o         (push),
    .entry_o        (push_entry),
    .q_full_i       (q_full)
  );

  maa_queue #(
    .WIDTH(EntryW)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_entry),
    .full_o (q_full),
    .pop_i  (pop),
    .data_o (pop_entry),
    .empty_o(q_empty)
  );

  maa_back #(
    .MAX_WINDOW(MAX_WINDOW)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .entry_i      (pop_entry),
    .q_empty_i    (q_empty),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .result_o     (result_o),
    .result_last_o(result_last_o)
  );

endmodule
